// ===== hdl/smif_pkg.sv =====
`timescale 1ns / 1ps
package smif_pkg;
	localparam int SERVO_COUNT = 6;
	localparam int STEP_MS = 20;
	localparam logic [9:0] DUTY_MAX = 10'd1000;
	localparam logic [11:0] STEPS_MAX = 12'd4095;
	localparam logic [15:0] DIRECT_LIMIT_MS = 16'd25;
	localparam logic [15:0] TICK_TIME_MS = 16'd20;
	localparam logic [9:0] GRIP_RESET = 10'd200;
	localparam int FRAME_LEN = 7 + 3 * SERVO_COUNT;
	localparam int SERVO_W = $clog2(SERVO_COUNT);
	localparam int BYTE_W = $clog2(FRAME_LEN);
	localparam logic [7:0] FRAME_HDR = 8'h55;
	localparam logic [7:0] CMD_MOVE = 8'd3;

	// Reciprocal of the step length, exact for every 16-bit move time.
	localparam int STEP_RECIP_SHIFT = 23;
	localparam int STEP_RECIP = ((1 << STEP_RECIP_SHIFT) + STEP_MS - 1) / STEP_MS;

	localparam logic [1:0] ACT_TARGET = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_GRIP = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [4:0] update_mask;
		logic [9:0] target_servo2;
		logic [9:0] target_servo3;
		logic [9:0] target_servo4;
		logic [9:0] target_servo5;
		logic [9:0] target_servo6;
		logic [9:0] grip_value;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic last_byte;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_SEND
	} state_t;

	// Divider control between sequencer and divider.
	typedef struct packed {
		logic start;
		logic [21:0] dividend;
		logic [11:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [21:0] quotient;
	} div_rsp_t;

	function automatic logic [9:0] sat_duty(input logic [9:0] v);
		return (v > DUTY_MAX) ? DUTY_MAX : v;
	endfunction
endpackage

// ===== hdl/servo_move_interpolator_framer_core.sv =====
`timescale 1ns / 1ps
// Servo move interpolator and framer.
// Input channel (in_valid/in_ready, payload in_beat) carries joint target,
// tick and grip update items. Output channel (out_valid/out_ready, payload
// out_beat) carries frame bytes, one per beat, with last_byte on byte 25.
// cfg_we/cfg_wdata write the move time register (reset 1000 ms).
// One item is taken at a time; in_ready is low until its frame is sent.
// Items without a frame leave the core idle. Direct frames go straight
// to sending. A tick with an intermediate frame runs the shared
// restoring divider once per servo 2..6,
// then sends 25 bytes.
// Reset restores servo 1 and grip to 200, all others to zero, and stops
// interpolation. When the receiver stalls, the current byte is held on the
// output register and the sequencer waits.
module servo_move_interpolator_framer_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input smif_pkg::in_beat_t in_beat,
	output logic out_valid,
	input logic out_ready,
	output smif_pkg::out_beat_t out_beat,
	input logic cfg_we,
	input logic [15:0] cfg_wdata
);
	localparam int N = smif_pkg::SERVO_COUNT;
	localparam int SW = smif_pkg::SERVO_W;
	localparam int BW = smif_pkg::BYTE_W;

	smif_pkg::state_t state_q, state_d;
	logic [15:0] move_time_q;
	logic [9:0] cur_q [N];
	logic [9:0] goal_q [N];
	logic signed [10:0] delta_q [N];
	logic [9:0] frame_q [N];
	logic [15:0] ftime_q;
	logic [11:0] total_q, left_q;
	logic active_q;
	logic [9:0] grip_q;
	logic [SW-1:0] sidx_q;
	logic [BW-1:0] bidx_q;
	logic [1:0] ph_q;
	logic [SW-1:0] fs_q;
	logic ov_q;
	smif_pkg::out_beat_t ob_q;

	smif_pkg::div_req_t dreq;
	smif_pkg::div_rsp_t drsp;
	smif_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic acc;
	assign in_ready = (state_q == smif_pkg::ST_IDLE);
	assign acc = in_valid && in_ready;

	// Targets of a joint item.
	logic [9:0] tgt [N];
	logic [9:0] tin [5];
	logic changed, all_zero;
	assign tin[0] = in_beat.target_servo2;
	assign tin[1] = in_beat.target_servo3;
	assign tin[2] = in_beat.target_servo4;
	assign tin[3] = in_beat.target_servo5;
	assign tin[4] = in_beat.target_servo6;
	always_comb begin
		changed = 1'b0;
		all_zero = 1'b1;
		for (int i = 0; i < N; i++) begin
			tgt[i] = cur_q[i];
			if (i == 0) tgt[i] = grip_q;
			else if (i <= 5 && in_beat.update_mask[i-1])
				tgt[i] = smif_pkg::sat_duty(tin[i-1]);
			if (tgt[i] != cur_q[i]) changed = 1'b1;
			if (cur_q[i] != '0) all_zero = 1'b0;
		end
	end

	// Step count by reciprocal multiplication.
	logic [38:0] steps_prod;
	logic [15:0] steps_raw;
	logic [11:0] steps;
	logic [9:0] gv;
	assign steps_prod = 39'(move_time_q) * 39'(smif_pkg::STEP_RECIP);
	assign steps_raw = steps_prod[smif_pkg::STEP_RECIP_SHIFT +: 16];
	assign steps = (steps_raw == '0) ? 12'd1 :
		(steps_raw > 16'(smif_pkg::STEPS_MAX)) ? smif_pkg::STEPS_MAX : steps_raw[11:0];
	assign gv = smif_pkg::sat_duty(in_beat.grip_value);

	// Dividend for the selected servo: goal*total - delta*(left-1).
	logic signed [24:0] num;
	logic [11:0] st;
	assign st = (total_q == '0) ? 12'd1 : total_q;
	assign num = $signed({3'b0, goal_q[sidx_q]}) * $signed({13'b0, st})
		- delta_q[sidx_q] * $signed({13'b0, left_q - 12'd1});
	logic dgo;
	always_comb begin
		dreq.start = (state_q == smif_pkg::ST_DIV_START) && !num[24];
		dreq.dividend = num[21:0];
		dreq.divisor = st;
	end
	assign dgo = (state_q == smif_pkg::ST_DIV_START);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smif_pkg::ST_IDLE: begin
				if (acc) begin
					unique case (in_beat.action)
						smif_pkg::ACT_TARGET:
							if (changed && !(move_time_q > smif_pkg::DIRECT_LIMIT_MS && !all_zero))
								state_d = smif_pkg::ST_SEND;
						smif_pkg::ACT_TICK:
							if (active_q)
								state_d = (left_q == '0) ? smif_pkg::ST_SEND
									: smif_pkg::ST_DIV_START;
						smif_pkg::ACT_GRIP:
							if (gv != grip_q) state_d = smif_pkg::ST_SEND;
						default: state_d = smif_pkg::ST_IDLE;
					endcase
				end
			end
			smif_pkg::ST_DIV_START:
				if (num[24])
					state_d = (sidx_q == SW'(N-1)) ? smif_pkg::ST_SEND : smif_pkg::ST_DIV_START;
				else state_d = smif_pkg::ST_DIV_WAIT;
			smif_pkg::ST_DIV_WAIT:
				if (drsp.done)
					state_d = (sidx_q == SW'(N-1)) ? smif_pkg::ST_SEND : smif_pkg::ST_DIV_START;
			smif_pkg::ST_SEND:
				if ((!ov_q || out_ready) && bidx_q == BW'(smif_pkg::FRAME_LEN))
					state_d = smif_pkg::ST_IDLE;
			default: state_d = smif_pkg::ST_IDLE;
		endcase
	end

	// Frame byte for the current index; servo bytes follow the servo and phase counters.
	logic [7:0] fbyte;
	always_comb begin
		case (bidx_q)
			BW'(0), BW'(1): fbyte = smif_pkg::FRAME_HDR;
			BW'(2): fbyte = 8'(5 + N * 3);
			BW'(3): fbyte = smif_pkg::CMD_MOVE;
			BW'(4): fbyte = 8'(N);
			BW'(5): fbyte = ftime_q[7:0];
			BW'(6): fbyte = ftime_q[15:8];
			default: begin
				case (ph_q)
					2'd0: fbyte = 8'(fs_q) + 8'd1;
					2'd1: fbyte = frame_q[fs_q][7:0];
					default: fbyte = {6'b0, frame_q[fs_q][9:8]};
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= smif_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_time_q <= 16'd1000;
			for (int i = 0; i < N; i++) begin
				cur_q[i] <= (i == 0) ? smif_pkg::GRIP_RESET : '0;
				goal_q[i] <= '0;
				delta_q[i] <= '0;
				frame_q[i] <= '0;
			end
			ftime_q <= '0;
			total_q <= '0;
			left_q <= '0;
			active_q <= 1'b0;
			grip_q <= smif_pkg::GRIP_RESET;
			sidx_q <= '0;
			bidx_q <= '0;
			ph_q <= '0;
			fs_q <= '0;
			ov_q <= 1'b0;
			ob_q <= '0;
		end else begin
			if (cfg_we) move_time_q <= cfg_wdata;
			if (acc) begin
				bidx_q <= '0;
				ph_q <= '0;
				fs_q <= '0;
				sidx_q <= SW'(1);
				unique case (in_beat.action)
					smif_pkg::ACT_TARGET: if (changed) begin
						if (move_time_q > smif_pkg::DIRECT_LIMIT_MS && !all_zero) begin
							total_q <= steps;
							left_q <= steps;
							active_q <= 1'b1;
							for (int i = 0; i < N; i++) begin
								goal_q[i] <= tgt[i];
								delta_q[i] <= (i == 0) ? 11'sd0 :
									$signed({1'b0, tgt[i]}) - $signed({1'b0, cur_q[i]});
							end
						end else begin
							ftime_q <= move_time_q;
							for (int i = 0; i < N; i++) begin
								cur_q[i] <= tgt[i];
								frame_q[i] <= tgt[i];
							end
						end
					end
					smif_pkg::ACT_TICK: if (active_q) begin
						ftime_q <= smif_pkg::TICK_TIME_MS;
						if (left_q == '0) begin
							active_q <= 1'b0;
							for (int i = 0; i < N; i++) begin
								cur_q[i] <= goal_q[i];
								frame_q[i] <= goal_q[i];
							end
						end else begin
							frame_q[0] <= grip_q;
						end
					end
					smif_pkg::ACT_GRIP: if (gv != grip_q) begin
						grip_q <= gv;
						cur_q[0] <= gv;
						active_q <= 1'b0;
						left_q <= '0;
						ftime_q <= smif_pkg::TICK_TIME_MS;
						frame_q[0] <= gv;
						for (int i = 1; i < N; i++) frame_q[i] <= cur_q[i];
					end
					default: ;
				endcase
			end
			// Per-servo division results.
			if ((dgo && num[24]) || (state_q == smif_pkg::ST_DIV_WAIT && drsp.done)) begin
				logic [9:0] d;
				d = (dgo || drsp.quotient > 22'(smif_pkg::DUTY_MAX)) ?
					(dgo ? 10'd0 : smif_pkg::DUTY_MAX) : drsp.quotient[9:0];
				frame_q[sidx_q] <= d;
				cur_q[sidx_q] <= d;
				sidx_q <= sidx_q + SW'(1);
				if (sidx_q == SW'(N-1)) begin
					left_q <= left_q - 12'd1;
					cur_q[0] <= grip_q;
				end
			end
			// Byte sender.
			if (state_q == smif_pkg::ST_SEND && (!ov_q || out_ready)
				&& bidx_q != BW'(smif_pkg::FRAME_LEN)) begin
				ob_q.frame_byte <= fbyte;
				ob_q.last_byte <= (bidx_q == BW'(smif_pkg::FRAME_LEN - 1));
				ov_q <= 1'b1;
				bidx_q <= bidx_q + BW'(1);
				if (bidx_q >= BW'(7)) begin
					if (ph_q == 2'd2) begin
						ph_q <= 2'd0;
						fs_q <= fs_q + SW'(1);
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_beat = ob_q;

`ifndef NO_ASSERTIONS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != smif_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smif_pkg::ST_IDLE && bidx_q != BW'(smif_pkg::FRAME_LEN) && bidx_q != '0)
		|-> 1'b0) else $error("frame cut short");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_beat)) else $error("beat changed");
`endif
endmodule

// ===== hdl/smif_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module smif_divider (
	input logic clk,
	input logic arst_n,
	input smif_pkg::div_req_t req,
	output smif_pkg::div_rsp_t rsp
);
	logic [21:0] quot_q;
	logic [11:0] rem_q;
	logic [11:0] dvs_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [12:0] trial;

	assign trial = {rem_q, quot_q[21]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd21) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-subtract datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[12]) begin
				rem_q <= trial[11:0];
				quot_q <= {quot_q[20:0], 1'b1};
			end else begin
				rem_q <= {rem_q[10:0], quot_q[21]};
				quot_q <= {quot_q[20:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quot_q;

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q != 5'd21) |=> busy_q)
		else $error("divider stopped early");
`endif
endmodule
